/* src/voc_pkg.sv */
// shared types and constants of the voxel occupancy run-length encoder
package voc_pkg;

    localparam int COORD_W    = 32;
    localparam int IDX_W      = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int RUN_W      = 8;
    localparam int CELL_IDX_W = 15;
    localparam int AXIS_OPS   = 6;

    localparam logic [RUN_W-1:0] RUN_CAP = 8'd255;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_AXIS,
        S_CHECK,
        S_MEM_RD,
        S_MEM_WR,
        S_RD_FETCH,
        S_RD_ALIGN,
        S_RD_COUNT
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] point;
        logic [COORD_W-1:0] origin;
    } t_axis_req;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } t_axis_res;

endpackage

/* src/voc_axis_unit.sv */
// shared pipelined unit mapping one coordinate to a signed voxel index
module voc_axis_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  voc_pkg::t_axis_req                  i_req,
    input  logic [voc_pkg::COORD_W-1:0]         i_scale,
    output voc_pkg::t_axis_res                  o_res
);
    import voc_pkg::*;

    logic                   r_s1_valid;
    logic                   r_s1_neg;
    logic [COORD_W-1:0]     r_s1_mag;
    logic                   r_s2_valid;
    logic                   r_s2_neg;
    logic [2*COORD_W-1:0]   r_s2_prod;
    logic                   r_s3_valid;
    logic [IDX_W-1:0]       r_s3_index;

    logic [COORD_W:0]       diff;
    logic [COORD_W:0]       diff_neg;
    logic [COORD_W:0]       hi_ext;
    logic                   big;
    logic                   small_pos;
    logic [IDX_W-1:0]       n_index;

    always_comb begin
        diff     = {i_req.point[COORD_W-1], i_req.point}
                 - {i_req.origin[COORD_W-1], i_req.origin};
        diff_neg = -diff;
        hi_ext   = {1'b0, r_s2_prod[2*COORD_W-1:COORD_W]};
        big       = !r_s2_neg && (r_s2_prod >= 64'h0000_0000_8000_0000);
        small_pos = !r_s2_neg && (r_s2_prod != '0);
        if (big) begin
            n_index = hi_ext;
        end else if (small_pos) begin
            n_index = '0;
        end else begin
            // -(m >> 32) - 1
            n_index = ~hi_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_neg   <= diff[COORD_W];
        r_s1_mag   <= diff[COORD_W] ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];
        r_s2_neg   <= r_s1_neg;
        r_s2_prod  <= r_s1_mag * i_scale;
        r_s3_index <= n_index;
    end

    assign o_res.valid = r_s3_valid;
    assign o_res.index = r_s3_index;

endmodule

/* src/voc_grid_mem.sv */
// occupancy memory, one grid row per word, registered read
module voc_grid_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic                      i_re,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/voxel_occupancy_rle_encoder.sv */
// top level: voxel occupancy grid with run-length readout
//
//  channel   direction  handshake                     payload
//  command   in         i_start, o_busy               i_func, i_point_x/y/z
//  result    out        o_done (one-cycle strobe)     o_in_grid, o_cell_index,
//                                                     o_seg_bit, o_seg_len,
//                                                     o_last_run, o_drained
//  config    in         i_cfg_valid, o_cfg_ready      i_cfg_index, i_cfg_data
//
//  insert: six passes through the index unit, then a bounds check, a row read and a row write
//  read: a fetch, align and count step per grid row the run touches; once drained it answers from idle
//  clear: one memory row per cycle over all GRID*GRID rows
//  after reset the same clearing pass runs with o_busy high
//  results are strobed for one cycle and cannot be held off
module voxel_occupancy_rle_encoder #(
    parameter int GRID = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [1:0]                            i_func,
    input  logic signed [voc_pkg::COORD_W-1:0]    i_point_x,
    input  logic signed [voc_pkg::COORD_W-1:0]    i_point_y,
    input  logic signed [voc_pkg::COORD_W-1:0]    i_point_z,
    output logic                                  o_done,
    output logic                                  o_in_grid,
    output logic [voc_pkg::CELL_IDX_W-1:0]        o_cell_index,
    output logic                                  o_seg_bit,
    output logic [voc_pkg::RUN_W-1:0]             o_seg_len,
    output logic                                  o_last_run,
    output logic                                  o_drained,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [voc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [voc_pkg::COORD_W-1:0]           i_cfg_data
);
    import voc_pkg::*;

    localparam int ROWS   = GRID * GRID;
    localparam int COL_W  = $clog2(GRID);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int RPOS_W = $clog2(ROWS + 1);
    localparam int CNT_W  = $clog2(GRID + 1);
    localparam int V_W    = IDX_W + 2;

    // configuration
    logic [COORD_W-1:0] r_origin [3];
    logic [COORD_W-1:0] r_center [3];
    logic [COORD_W-1:0] r_scale;

    // payload
    logic [COORD_W-1:0] r_pt [3];
    logic [IDX_W-1:0]   r_idx [AXIS_OPS];

    // control and datapath
    t_state             r_state, n_state;
    logic [2:0]         r_issue, n_issue;
    logic [2:0]         r_collect, n_collect;
    logic [COL_W-1:0]   r_sx, n_sx;
    logic [COL_W-1:0]   r_sy, n_sy;
    logic [COL_W-1:0]   r_sz, n_sz;
    logic [RPOS_W-1:0]  r_rrow, n_rrow;
    logic [COL_W-1:0]   r_rcol, n_rcol;
    logic               r_rfin, n_rfin;
    logic [RUN_W-1:0]   r_len, n_len;
    logic               r_val, n_val;
    logic [GRID:0]      r_span, n_span;
    logic [ROW_W-1:0]   r_clr, n_clr;
    logic               r_clr_ack, n_clr_ack;

    logic                  r_done, n_done;
    logic                  r_in_grid, n_in_grid;
    logic [CELL_IDX_W-1:0] r_cell_index, n_cell_index;
    logic                  r_seg_bit, n_seg_bit;
    logic [RUN_W-1:0]      r_seg_len, n_seg_len;
    logic                  r_last_run, n_last_run;
    logic                  r_drained, n_drained;

    // shared index unit
    t_axis_req          ax_req;
    t_axis_res          ax_res;
    logic [1:0]         ax_sel;

    // memory
    logic               mem_we;
    logic [ROW_W-1:0]   mem_waddr;
    logic [GRID-1:0]    mem_wdata;
    logic               mem_re;
    logic [ROW_W-1:0]   mem_raddr;
    logic [GRID-1:0]    mem_rdata;

    // insert helpers
    logic [V_W-1:0]     chk_v [3];
    logic               chk_ok;
    logic [31:0]        ins_row32;
    logic [31:0]        ins_lin32;
    logic [ROW_W-1:0]   ins_row;

    // scan helpers
    logic               aln_val;
    logic [GRID-1:0]    aln_mism;
    logic [CNT_W-1:0]   scan_first;
    logic [RUN_W-1:0]   scan_room;
    logic [RUN_W-1:0]   scan_take;
    logic [RUN_W-1:0]   scan_col;
    logic [RUN_W-1:0]   scan_len;
    logic               scan_row_end;
    logic [RPOS_W-1:0]  scan_row;
    logic               scan_last;

    function automatic logic [CNT_W-1:0] first_one(input logic [GRID:0] v);
        logic [CNT_W-1:0] pos;
        pos = '0;
        for (int i = GRID; i >= 0; i--) begin
            if (v[i]) begin
                pos = CNT_W'(i);
            end
        end
        return pos;
    endfunction

    voc_axis_unit u_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ax_req),
        .i_scale (r_scale),
        .o_res   (ax_res)
    );

    voc_grid_mem #(
        .WIDTH (GRID),
        .DEPTH (ROWS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // operand select for the index unit: points first, then centers
    always_comb begin
        ax_sel        = (r_issue < 3'd3) ? r_issue[1:0] : 2'(r_issue - 3'd3);
        ax_req.valid  = (r_state == S_AXIS) && (r_issue < 3'(AXIS_OPS));
        ax_req.point  = (r_issue < 3'd3) ? r_pt[ax_sel] : r_center[ax_sel];
        ax_req.origin = r_origin[ax_sel];
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            chk_v[k] = {{2{r_idx[k][IDX_W-1]}}, r_idx[k]}
                     - {{2{r_idx[k+3][IDX_W-1]}}, r_idx[k+3]}
                     + V_W'(GRID / 2);
        end
        chk_ok = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (chk_v[k][V_W-1] || (chk_v[k][V_W-2:0] >= (V_W-1)'(GRID))) begin
                chk_ok = 1'b0;
            end
        end
        ins_row32 = 32'(r_sx) * 32'(GRID) + 32'(r_sz);
        ins_lin32 = ins_row32 * 32'(GRID) + 32'(r_sy);
        ins_row   = ins_row32[ROW_W-1:0];
    end

    always_comb begin
        aln_val      = (r_len == '0) ? mem_rdata[r_rcol] : r_val;
        aln_mism     = mem_rdata ^ {GRID{aln_val}};
        scan_first   = first_one(r_span);
        scan_room    = RUN_CAP - r_len;
        scan_take    = (RUN_W'(scan_first) < scan_room) ? RUN_W'(scan_first) : scan_room;
        scan_col     = RUN_W'(r_rcol) + scan_take;
        scan_len     = r_len + scan_take;
        scan_row_end = (scan_col == RUN_W'(GRID));
        scan_row     = r_rrow + RPOS_W'(scan_row_end);
        scan_last    = (scan_row == RPOS_W'(ROWS));
    end

    always_comb begin
        n_state      = r_state;
        n_issue      = r_issue;
        n_collect    = r_collect;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_sz         = r_sz;
        n_rrow       = r_rrow;
        n_rcol       = r_rcol;
        n_rfin       = r_rfin;
        n_len        = r_len;
        n_val        = r_val;
        n_span       = r_span;
        n_clr        = r_clr;
        n_clr_ack    = r_clr_ack;
        n_done       = 1'b0;
        n_in_grid    = 1'b0;
        n_cell_index = '0;
        n_seg_bit    = 1'b0;
        n_seg_len    = '0;
        n_last_run   = 1'b0;
        n_drained    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = ins_row;
        mem_wdata    = mem_rdata | (GRID'(1) << r_sy);
        mem_re       = 1'b0;
        mem_raddr    = r_rrow[ROW_W-1:0];

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == ROW_W'(ROWS - 1)) begin
                    n_state   = S_IDLE;
                    n_clr_ack = 1'b0;
                    n_done    = r_clr_ack;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    case (i_func)
                        FUNC_INSERT: begin
                            n_issue   = '0;
                            n_collect = '0;
                            n_state   = S_AXIS;
                        end
                        FUNC_READ: begin
                            if (r_rfin || (r_rrow == RPOS_W'(ROWS))) begin
                                n_rfin    = 1'b1;
                                n_done    = 1'b1;
                                n_drained = 1'b1;
                            end else begin
                                n_len   = '0;
                                n_state = S_RD_FETCH;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_clr     = '0;
                            n_clr_ack = 1'b1;
                            n_rrow    = '0;
                            n_rcol    = '0;
                            n_rfin    = 1'b0;
                            n_state   = S_CLEAR;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_AXIS: begin
                if (ax_req.valid) begin
                    n_issue = r_issue + 1'b1;
                end
                if (ax_res.valid) begin
                    n_collect = r_collect + 1'b1;
                    if (r_collect == 3'(AXIS_OPS - 1)) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (chk_ok) begin
                    n_sx    = chk_v[0][COL_W-1:0];
                    n_sy    = chk_v[1][COL_W-1:0];
                    n_sz    = chk_v[2][COL_W-1:0];
                    n_state = S_MEM_RD;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MEM_RD: begin
                mem_re    = 1'b1;
                mem_raddr = ins_row;
                n_state   = S_MEM_WR;
            end
            S_MEM_WR: begin
                mem_we       = 1'b1;
                n_done       = 1'b1;
                n_in_grid    = 1'b1;
                n_cell_index = ins_lin32[CELL_IDX_W-1:0];
                n_state      = S_IDLE;
            end
            S_RD_FETCH: begin
                mem_re  = 1'b1;
                n_state = S_RD_ALIGN;
            end
            S_RD_ALIGN: begin
                // sentinel above the row stops the run at the row end
                n_val   = aln_val;
                n_span  = {1'b1, aln_mism} >> r_rcol;
                n_state = S_RD_COUNT;
            end
            S_RD_COUNT: begin
                n_len  = scan_len;
                n_rrow = scan_row;
                n_rcol = scan_row_end ? '0 : scan_col[COL_W-1:0];
                if ((scan_len == RUN_CAP) || !scan_row_end || scan_last) begin
                    n_done       = 1'b1;
                    n_seg_bit    = r_val;
                    n_seg_len    = scan_len;
                    n_last_run   = scan_last;
                    n_rfin       = r_rfin | scan_last;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_RD_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_issue      <= '0;
            r_collect    <= '0;
            r_rrow       <= '0;
            r_rcol       <= '0;
            r_rfin       <= 1'b0;
            r_len        <= '0;
            r_clr        <= '0;
            r_clr_ack    <= 1'b0;
            r_done       <= 1'b0;
            r_in_grid    <= 1'b0;
            r_cell_index <= '0;
            r_seg_bit    <= 1'b0;
            r_seg_len    <= '0;
            r_last_run   <= 1'b0;
            r_drained    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue      <= n_issue;
            r_collect    <= n_collect;
            r_rrow       <= n_rrow;
            r_rcol       <= n_rcol;
            r_rfin       <= n_rfin;
            r_len        <= n_len;
            r_clr        <= n_clr;
            r_clr_ack    <= n_clr_ack;
            r_done       <= n_done;
            r_in_grid    <= n_in_grid;
            r_cell_index <= n_cell_index;
            r_seg_bit    <= n_seg_bit;
            r_seg_len    <= n_seg_len;
            r_last_run   <= n_last_run;
            r_drained    <= n_drained;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_sz   <= n_sz;
        r_val  <= n_val;
        r_span <= n_span;
        if ((r_state == S_IDLE) && i_start) begin
            r_pt[0] <= i_point_x;
            r_pt[1] <= i_point_y;
            r_pt[2] <= i_point_z;
        end
        if ((r_state == S_AXIS) && ax_res.valid) begin
            r_idx[r_collect] <= ax_res.index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin[0] <= '0;
            r_origin[1] <= '0;
            r_origin[2] <= '0;
            r_scale     <= 32'h0001_0000;
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORIGIN_X: r_origin[0] <= i_cfg_data;
                CFG_ORIGIN_Y: r_origin[1] <= i_cfg_data;
                CFG_ORIGIN_Z: r_origin[2] <= i_cfg_data;
                CFG_CELLS:    r_scale     <= i_cfg_data;
                CFG_CENTER_X: r_center[0] <= i_cfg_data;
                CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_in_grid    = r_in_grid;
    assign o_cell_index = r_cell_index;
    assign o_seg_bit    = r_seg_bit;
    assign o_seg_len    = r_seg_len;
    assign o_last_run   = r_last_run;
    assign o_drained    = r_drained;

    // a result only follows an accepted request or busy work
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(i_start) || $past(o_busy)))
        else $error("result strobe without request");

    // drained result carries no run
    a_drained_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_drained) |-> (!o_seg_bit && (o_seg_len == '0) && !o_last_run))
        else $error("drained result with run fields");

    // last run marks the readout finished
    a_last_sets_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_run |-> r_rfin)
        else $error("last run without finished flag");

    // index unit results only arrive while they are being collected
    a_axis_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_AXIS) |-> !ax_res.valid)
        else $error("stray index result");

endmodule
